>>> hw/rtl/tlj_pkg.sv
// ----------------------------------------------------------------------------
// tlj_pkg
// Shared types and constants for the text line justifier.
// ----------------------------------------------------------------------------
package tlj_pkg;

    localparam int MAX_WIDTH_DEF = 32;
    localparam int MAX_WORDS_DEF = 16;
    localparam int LEN_W         = 6;
    localparam int CHAR_W        = 8;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
    localparam logic [LEN_W-1:0]  WIDTH_RESET = 6'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DECIDE,
        ST_SETUP,
        ST_DIV,
        ST_EMIT,
        ST_APPEND
    } tlj_state_t;

    typedef enum logic [1:0] {
        PH_WORD,
        PH_GAP,
        PH_PAD
    } tlj_phase_t;

    // divider control and status
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } tlj_div_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] quot;
        logic [LEN_W-1:0] rem;
    } tlj_div_rsp_t;

endpackage

>>> hw/rtl/tlj_div.sv
// ----------------------------------------------------------------------------
// tlj_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlj_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlj_pkg::tlj_div_req_t req,
    output tlj_pkg::tlj_div_rsp_t rsp
);
    import tlj_pkg::*;

    localparam int STEP_W = $clog2(LEN_W + 1);

    logic                busy_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [LEN_W-1:0]    quo_reg;
    logic [LEN_W-1:0]    dvs_reg;
    logic                done_reg;
    logic [LEN_W:0]      trial;
    logic [LEN_W:0]      diff;

    // one shift-subtract step
    assign trial = {rem_reg, quo_reg[LEN_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                if (!diff[LEN_W])
                begin
                    rem_reg <= diff[LEN_W-1:0];
                    quo_reg <= {quo_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[LEN_W-1:0];
                    quo_reg <= {quo_reg[LEN_W-2:0], 1'b0};
                end
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(LEN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> hw/rtl/text_line_full_justifier_top.sv
// ----------------------------------------------------------------------------
// text_line_full_justifier_top
// Greedy line filler with full justification of emitted lines.
// ----------------------------------------------------------------------------
// flow: a character that does not close a word is stored while idle; a word
// close runs clamp and decide, then copies its letters into the held line;
// an emitted line goes through setup, the divider when fully justified, then emit.
// output: at most one line character per cycle, stalled while out_ready is low.
// reset: asynchronous active low, clears counts and flags, width back to 16.
module text_line_full_justifier_top
#(
    parameter int MAX_WIDTH = tlj_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WORDS = tlj_pkg::MAX_WORDS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tlj_pkg::CHAR_W-1:0]  char_byte,
    input  logic                        word_end,
    input  logic                        text_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tlj_pkg::CHAR_W-1:0]  char_out,
    output logic                        line_end,
    output logic                        run_last,
    output logic                        text_done,
    output logic                        word_cut,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tlj_pkg::LEN_W-1:0]   cfg_data
);
    import tlj_pkg::*;

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WIX = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    tlj_state_t state_reg, state_next;
    tlj_phase_t phase_reg;

    logic [LEN_W-1:0]  width_reg;
    logic [CHAR_W-1:0] pend_mem_reg [MAX_WIDTH];
    logic [CHAR_W-1:0] line_mem_reg [MAX_WIDTH];
    logic [LEN_W-1:0]  wlen_mem_reg [MAX_WORDS];

    logic [LEN_W-1:0]  llc_reg, lwc_reg, pl_reg;
    logic              cut_reg, pcut_reg, te_reg, last_reg;
    logic [LEN_W-1:0]  pos_reg, src_reg, j_reg, k_reg, ak_reg, s_reg;
    logic [LEN_W-1:0]  even_reg, extra_reg;

    logic              out_valid_reg, line_end_reg, run_last_reg;
    logic              text_done_reg, word_cut_reg;
    logic [CHAR_W-1:0] char_out_reg;

    logic [LEN_W-1:0]  w_eff;
    logic              slot_free;
    logic              emit_fire;
    logic [CHAR_W-1:0] emit_char;
    logic [LEN_W-1:0]  wlen_cur;
    logic [LEN_W-1:0]  gaps;
    logic              full_ok;
    logic              need_emit;
    logic [LEN_W:0]    fit_sum;

    tlj_div_req_t div_req;
    tlj_div_rsp_t div_rsp;

    tlj_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // effective width saturated to 1..MAX_WIDTH
    always_comb
    begin
        if (width_reg == '0)
            w_eff = LEN_W'(1);
        else if (width_reg > LEN_W'(MAX_WIDTH))
            w_eff = LEN_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign wlen_cur  = wlen_mem_reg[j_reg[WIX-1:0]];
    assign gaps      = (lwc_reg != '0) ? lwc_reg - 1'b1 : '0;
    assign full_ok   = !last_reg && (lwc_reg > LEN_W'(1))
                       && ({1'b0, llc_reg} + {1'b0, gaps} <= {1'b0, w_eff});
    assign fit_sum   = {1'b0, llc_reg} + {1'b0, lwc_reg} + {1'b0, pl_reg};
    assign need_emit = (lwc_reg != '0)
                       && ((lwc_reg >= LEN_W'(MAX_WORDS)) || (fit_sum > {1'b0, w_eff}));

    assign div_req.start    = (state_reg == ST_SETUP) && full_ok;
    assign div_req.dividend = w_eff - llc_reg;
    assign div_req.divisor  = gaps;

    // next state and emitter decode
    always_comb
    begin
        state_next = state_reg;
        emit_fire  = 1'b0;
        emit_char  = SPACE_CHAR;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = (word_end || text_end) ? ST_CLAMP : ST_IDLE;
            end
            ST_CLAMP:
                state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = need_emit ? ST_SETUP : ST_APPEND;
            ST_SETUP:
                state_next = full_ok ? ST_DIV : ST_EMIT;
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    case (phase_reg)
                        PH_WORD:
                        begin
                            if (j_reg < lwc_reg && k_reg < wlen_cur)
                            begin
                                emit_fire = 1'b1;
                                emit_char = line_mem_reg[src_reg[AW-1:0]];
                            end
                        end
                        PH_GAP:
                            emit_fire = (s_reg != '0);
                        default:
                            emit_fire = 1'b1;
                    endcase
                    if (emit_fire && pos_reg == w_eff - 1'b1)
                        state_next = last_reg ? ST_IDLE : ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                if (!(ak_reg < pl_reg && llc_reg < LEN_W'(MAX_WIDTH)))
                    state_next = te_reg ? ST_SETUP : ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= WIDTH_RESET;
        else if (cfg_valid && cfg_ready)
            width_reg <= cfg_data;
    end

    // datapath and control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            llc_reg       <= '0;
            lwc_reg       <= '0;
            pl_reg        <= '0;
            cut_reg       <= 1'b0;
            pcut_reg      <= 1'b0;
            te_reg        <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_WORD;
        end
        else
        begin
            if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                // store the incoming character of the pending word
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        te_reg   <= text_end;
                        last_reg <= 1'b0;
                        if (pl_reg < w_eff)
                        begin
                            pend_mem_reg[pl_reg[AW-1:0]] <= char_byte;
                            pl_reg <= pl_reg + 1'b1;
                        end
                        else
                            pcut_reg <= 1'b1;
                    end
                end
                // word longer than a lowered width
                ST_CLAMP:
                begin
                    if (pl_reg > w_eff)
                    begin
                        pl_reg   <= w_eff;
                        pcut_reg <= 1'b1;
                    end
                end
                ST_SETUP:
                begin
                    pos_reg   <= '0;
                    src_reg   <= '0;
                    j_reg     <= '0;
                    k_reg     <= '0;
                    phase_reg <= PH_WORD;
                    even_reg  <= LEN_W'(1);
                    extra_reg <= '0;
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        even_reg  <= div_rsp.quot;
                        extra_reg <= div_rsp.rem;
                    end
                end
                // at most one line character per free output slot
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        if (emit_fire)
                        begin
                            out_valid_reg <= 1'b1;
                            char_out_reg  <= emit_char;
                            line_end_reg  <= (pos_reg == w_eff - 1'b1);
                            run_last_reg  <= (pos_reg == w_eff - 1'b1) && (last_reg || !te_reg);
                            text_done_reg <= (pos_reg == w_eff - 1'b1) && last_reg;
                            word_cut_reg  <= cut_reg;
                            pos_reg       <= pos_reg + 1'b1;
                            if (phase_reg == PH_WORD)
                            begin
                                src_reg <= src_reg + 1'b1;
                                k_reg   <= k_reg + 1'b1;
                            end
                            if (phase_reg == PH_GAP)
                                s_reg <= s_reg - 1'b1;
                            if (pos_reg == w_eff - 1'b1)
                            begin
                                llc_reg <= '0;
                                lwc_reg <= '0;
                                cut_reg <= 1'b0;
                                ak_reg  <= '0;
                            end
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_WORD:
                                begin
                                    if (j_reg + 1'b1 < lwc_reg)
                                    begin
                                        phase_reg <= PH_GAP;
                                        s_reg     <= even_reg
                                                     + ((j_reg < extra_reg) ? LEN_W'(1) : '0);
                                    end
                                    else
                                        phase_reg <= PH_PAD;
                                end
                                PH_GAP:
                                begin
                                    phase_reg <= PH_WORD;
                                    j_reg     <= j_reg + 1'b1;
                                    k_reg     <= '0;
                                end
                                default:
                                    phase_reg <= PH_PAD;
                            endcase
                        end
                    end
                end
                // copy the pending word into the held line
                ST_APPEND:
                begin
                    if (ak_reg < pl_reg && llc_reg < LEN_W'(MAX_WIDTH))
                    begin
                        line_mem_reg[llc_reg[AW-1:0]] <= pend_mem_reg[ak_reg[AW-1:0]];
                        llc_reg <= llc_reg + 1'b1;
                        ak_reg  <= ak_reg + 1'b1;
                    end
                    else
                    begin
                        wlen_mem_reg[lwc_reg[WIX-1:0]] <= ak_reg;
                        lwc_reg  <= lwc_reg + 1'b1;
                        cut_reg  <= cut_reg | pcut_reg;
                        pl_reg   <= '0;
                        pcut_reg <= 1'b0;
                        if (te_reg)
                            last_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            // copy index starts fresh on every word close
            if (state_reg == ST_DECIDE)
                ak_reg <= '0;
        end
    end

    // width changes only between transactions while idle
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;
    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;
    assign line_end  = line_end_reg;
    assign run_last  = run_last_reg;
    assign text_done = text_done_reg;
    assign word_cut  = word_cut_reg;

endmodule

>>> tb/text_line_full_justifier_top_tb.sv
// ----------------------------------------------------------------------------
// text_line_full_justifier_top_tb
// Drives word characters through the justifier under random backpressure and
// checks every emitted line character against a built-in line formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_line_full_justifier_top_tb;

    import tlj_pkg::*;

    localparam int MAXW     = MAX_WIDTH_DEF;
    localparam int MAXWORDS = MAX_WORDS_DEF;
    localparam int CFG_MAX_WIDTH = 0;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_DIR = 14;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              wend;
        logic              tend;
    } char_txn_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              lend;
        logic              rlast;
        logic              tdone;
        logic              cut;
    } line_char_t;

    // directed stimulus row: width to apply (0 keeps current, first row applies 16),
    // one character, and a typed-in expected first result where it is obvious
    typedef struct {
        int        width;
        char_txn_t txn;
        bit        has_exp;
        line_char_t exp_first;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CHAR_W-1:0] char_byte;
    logic              word_end;
    logic              text_end;
    logic              out_valid;
    logic              out_ready;
    logic [CHAR_W-1:0] char_out;
    logic              line_end;
    logic              run_last;
    logic              text_done;
    logic              word_cut;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data;

    // formatter state
    logic [CHAR_W-1:0] held_chars [MAXW];
    int                held_lens  [MAXWORDS];
    logic [CHAR_W-1:0] word_chars [MAXW];
    int                held_letters;
    int                held_words;
    int                word_len;
    bit                held_cut;
    bit                word_cut_flag;
    logic [LEN_W-1:0]  width_reg;

    line_char_t expected_chars [$];
    int  errors;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  idle_cycles;
    bit  timed_out;

    text_line_full_justifier_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .word_end  (word_end),
        .text_end  (text_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .line_end  (line_end),
        .run_last  (run_last),
        .text_done (text_done),
        .word_cut  (word_cut),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int line_width();
        if (width_reg < 1)
            return 1;
        if (width_reg > MAXW)
            return MAXW;
        return int'(width_reg);
    endfunction

    // append one formatted line to the expected queue
    function automatic void format_line(int w, bit full, bit last);
        logic [CHAR_W-1:0] buf_line [MAXW];
        int pos;
        int src;
        int gaps;
        int spare;
        int even;
        int extra;
        int s;
        line_char_t lc;
        pos = 0;
        src = 0;
        gaps = held_words > 0 ? held_words - 1 : 0;
        if (full && held_words > 1 && held_letters + gaps <= w)
        begin
            spare = w - held_letters;
            even  = spare / gaps;
            extra = spare % gaps;
            for (int j = 0; j < held_words; j++)
            begin
                for (int k = 0; k < held_lens[j] && pos < w; k++)
                begin
                    buf_line[pos] = held_chars[src];
                    pos++;
                    src++;
                end
                if (j < gaps)
                begin
                    s = even + (j < extra ? 1 : 0);
                    for (int k = 0; k < s && pos < w; k++)
                    begin
                        buf_line[pos] = SPACE_CHAR;
                        pos++;
                    end
                end
            end
        end
        else
        begin
            for (int j = 0; j < held_words; j++)
            begin
                if (j > 0 && pos < w)
                begin
                    buf_line[pos] = SPACE_CHAR;
                    pos++;
                end
                for (int k = 0; k < held_lens[j]; k++)
                begin
                    if (pos < w)
                    begin
                        buf_line[pos] = held_chars[src];
                        pos++;
                    end
                    src++;
                end
            end
        end
        while (pos < w)
        begin
            buf_line[pos] = SPACE_CHAR;
            pos++;
        end
        for (int k = 0; k < w; k++)
        begin
            lc.ch    = buf_line[k];
            lc.lend  = (k == w - 1);
            lc.rlast = 1'b0;
            lc.tdone = last && (k == w - 1);
            lc.cut   = held_cut;
            expected_chars = {expected_chars, lc};
        end
        held_letters = 0;
        held_words   = 0;
        held_cut     = 0;
    endfunction

    // predict the line characters caused by one accepted character
    function automatic int justify_char(char_txn_t t);
        int w;
        int before_n;
        int k;
        bit wend;
        w = line_width();
        before_n = expected_chars.size();
        wend = t.wend || t.tend;
        if (word_len < w)
        begin
            word_chars[word_len] = t.ch;
            word_len++;
        end
        else
            word_cut_flag = 1;
        if (wend)
        begin
            if (word_len > w)
            begin
                word_len = w;
                word_cut_flag = 1;
            end
            if (held_words > 0 && (held_words >= MAXWORDS ||
                held_letters + held_words + word_len > w))
                format_line(w, 1, 0);
            for (k = 0; k < word_len && held_letters < MAXW; k++)
            begin
                held_chars[held_letters] = word_chars[k];
                held_letters++;
            end
            held_lens[held_words] = k;
            held_words++;
            held_cut |= word_cut_flag;
            word_len = 0;
            word_cut_flag = 0;
            if (t.tend)
                format_line(w, 0, 1);
        end
        if (expected_chars.size() > before_n)
            expected_chars[expected_chars.size() - 1].rlast = 1'b1;
        return expected_chars.size() - before_n;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        line_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
                report_mismatch("unexpected line character", char_out, -1);
            else
            begin
                want = expected_chars.pop_front();
                if (char_out !== want.ch)
                    report_mismatch("char_out", char_out, want.ch);
                if (line_end !== want.lend)
                    report_mismatch("line_end", line_end, want.lend);
                if (run_last !== want.rlast)
                    report_mismatch("run_last", run_last, want.rlast);
                if (text_done !== want.tdone)
                    report_mismatch("text_done", text_done, want.tdone);
                if (word_cut !== want.cut)
                    report_mismatch("word_cut", word_cut, want.cut);
            end
        end
    end

    // receiver ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("simulation failed");
            $finish;
        end
    end

    // sender goes quiet until every expected line character has come
    task automatic drain_lines();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_width(int w);
        cfg_valid <= 1'b1;
        cfg_data  <= w[LEN_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        width_reg = w[LEN_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // valid stays high after a transaction until the next idle or drain
    task automatic send_char(char_txn_t t);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= t.ch;
        word_end  <= t.wend;
        text_end  <= t.tend;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        void'(justify_char(t));
    endtask

    // one random word of given length; last character may close the text
    task automatic send_word(int len, bit close_text);
        char_txn_t t;
        for (int i = 0; i < len; i++)
        begin
            t.ch   = CHAR_W'($urandom_range(255));
            if (t.ch == SPACE_CHAR && $urandom_range(3) != 0)
                t.ch = CHAR_W'(8'h41 + $urandom_range(25));
            t.wend = (i == len - 1);
            t.tend = (i == len - 1) && close_text;
            send_char(t);
        end
    endtask

    // random text: mostly short words, a few long or odd marks
    task automatic send_text(int words);
        int len;
        int r;
        char_txn_t t;
        for (int i = 0; i < words; i++)
        begin
            r = $urandom_range(99);
            if (r < 5)
                len = $urandom_range(34, 40);
            else
                len = $urandom_range(1, 6);
            if (r == 99)
            begin
                // text end without word end
                t.ch = CHAR_W'($urandom_range(255));
                t.wend = 0;
                t.tend = 1;
                send_char(t);
            end
            else
                send_word(len, i == words - 1);
        end
    endtask

    // directed table: extremes of char, single-word lines, overlong words,
    // width saturation, text end without word end, full justification
    dir_row_t dir_rows [N_DIR] = '{
        '{0,  '{8'hFF, 1, 1}, 1, '{8'hFF, 0, 0, 0, 0}},
        '{1,  '{8'h00, 0, 0}, 0, '{default:0}},
        '{0,  '{8'h7E, 0, 1}, 1, '{8'h00, 1, 1, 1, 1}},
        '{32, '{8'h61, 1, 0}, 0, '{default:0}},
        '{0,  '{8'h20, 1, 0}, 0, '{default:0}},
        '{0,  '{8'hAA, 0, 0}, 0, '{default:0}},
        '{0,  '{8'h55, 1, 1}, 0, '{default:0}},
        '{63, '{8'h01, 1, 1}, 1, '{8'h01, 0, 0, 0, 0}},
        '{4,  '{8'h41, 0, 0}, 0, '{default:0}},
        '{0,  '{8'h42, 1, 0}, 0, '{default:0}},
        '{0,  '{8'h43, 1, 0}, 0, '{default:0}},
        '{0,  '{8'h44, 1, 0}, 0, '{default:0}},
        '{0,  '{8'h45, 1, 1}, 0, '{default:0}},
        '{0,  '{8'h80, 1, 0}, 0, '{default:0}}
    };
    int widths [8] = '{16, 1, 32, 0, 63, 5, 10, 7};

    initial
    begin
        dir_row_t row;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_byte = '0;
        word_end  = 1'b0;
        text_end  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        recv_hold = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        errors = 0;
        idle_cycles = 0;
        timed_out = 0;
        held_letters = 0;
        held_words = 0;
        word_len = 0;
        held_cut = 0;
        word_cut_flag = 0;
        width_reg = WIDTH_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // typed rows meet an empty queue, so their first result heads the queue
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.width != 0 || i == 0)
            begin
                drain_lines();
                write_width(row.width == 0 ? 16 : row.width);
            end
            send_char(row.txn);
            if (row.has_exp &&
                (expected_chars.size() == 0 || expected_chars[0] !== row.exp_first))
                report_mismatch("directed row", i, i);
        end
        // close the text after the last row with a one-letter word
        send_word(1, 1);
        drain_lines();
        // width 1: a single char and text end gives one closing char
        write_width(1);
        send_char('{8'hFF, 1, 1});
        if (expected_chars.size() != 1 ||
            expected_chars[0] !== line_char_t'{8'hFF, 1, 1, 1, 0})
            report_mismatch("width one prediction", expected_chars.size(), 1);
        drain_lines();

        // random phases with width changes
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 37;
                recv_idle_pct = 74;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain_lines();
            write_width(widths[phase]);
            if (phase == 6)
            begin
                // long receiver hold while the sender keeps offering
                fork
                    begin
                        recv_hold = 1;
                        repeat (400) @(posedge clk);
                        recv_hold = 0;
                    end
                    send_text(14);
                join
            end
            else
                send_text(10);
            // width lowered while a line is held
            if (phase == 2)
            begin
                send_word(3, 0);
                send_word(4, 0);
                drain_lines();
                write_width(2);
                send_word(5, 1);
            end
        end
        drain_lines();

        if (errors == 0 && expected_chars.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
